@@ hw/rtl/ascii_last_number_extractor_macros.svh @@
// Assertion macros used by the checker file of the number extractor.
`ifndef ASCII_LAST_NUMBER_EXTRACTOR_MACROS_SVH
`define ASCII_LAST_NUMBER_EXTRACTOR_MACROS_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define ALNE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high.
`define ALNE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/alne_pkg.sv @@
// Shared types, constants and helpers of the last-number extractor.
package alne_pkg;

   localparam int BUFFER_BYTES_DEFAULT = 64;
   localparam int QUEUE_DEPTH          = 4;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_POINT = 8'h2E;

   localparam logic [31:0] MAG_CAP     = 32'h8000_0000;
   localparam logic [2:0]  FRAC_KEEP   = 3'd4;
   localparam logic [3:0]  ROUND_DIGIT = 4'd5;
   localparam int          SCALE_W     = 14;
   localparam int          PROD_W      = 32 + SCALE_W;

   typedef enum logic [1:0] {
      CLS_OTHER,
      CLS_DIGIT,
      CLS_POINT,
      CLS_SIGN
   } char_class_type;

   typedef struct packed {
      char_class_type cls;
      logic           negative;
      logic [3:0]     digit;
      logic           scan_en;
      logic           last;
   } scan_item_type;

   typedef struct packed {
      logic        fin_valid;
      logic        emit;
      logic        negative;
      logic        round_up;
      logic        overflow;
      logic [2:0]  frac_digits;
      logic [31:0] mag;
   } finish_type;

   // Scale that brings a magnitude with the given fraction digits to 1e-4 units.
   function automatic logic [SCALE_W-1:0] scale_factor(input logic [2:0] frac_digits);
      logic [SCALE_W-1:0] f;
      case (frac_digits)
         3'd0:    f = SCALE_W'(10000);
         3'd1:    f = SCALE_W'(1000);
         3'd2:    f = SCALE_W'(100);
         3'd3:    f = SCALE_W'(10);
         default: f = SCALE_W'(1);
      endcase
      return f;
   endfunction

endpackage

@@ hw/rtl/alne_req_if.sv @@
// Byte channel into the extractor: valid, ready, one text byte and its last-byte flag.
interface alne_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

@@ hw/rtl/alne_rsp_if.sv @@
// Result channel out of the extractor: valid, ready, the found flag and the parsed number.
interface alne_rsp_if;
   logic               valid;
   logic               ready;
   logic               number_found;
   logic signed [31:0] value;

   modport source (output valid, output number_found, output value, input ready);
   modport sink   (input valid, input number_found, input value, output ready);
endinterface

@@ hw/rtl/alne_fifo.sv @@
// Short register queue between the byte classifier and the token scanner.
module alne_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  alne_pkg::scan_item_type push_item,
   input  logic                  pop,
   output alne_pkg::scan_item_type head_item,
   output logic                  not_empty,
   output logic                  full
);
   import alne_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   scan_item_type          store_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;

   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_item = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_item;
      end
   end
endmodule

@@ hw/rtl/alne_front.sv @@
// Front end: takes bytes, counts them against the buffer limit, classifies them.
module alne_front #(
   parameter int BUFFER_BYTES = alne_pkg::BUFFER_BYTES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   alne_req_if.sink               req_bus,
   input  logic                   queue_full,
   output logic                   push,
   output alne_pkg::scan_item_type push_item
);
   import alne_pkg::*;

   localparam int              CNT_W = $clog2(BUFFER_BYTES);
   localparam logic [CNT_W-1:0] LIMIT = CNT_W'(BUFFER_BYTES - 1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             scan_en;
   logic [7:0]       c;

   assign c             = req_bus.data_byte;
   assign req_bus.ready = !queue_full;
   assign push          = req_bus.valid && !queue_full;
   assign scan_en       = (count_ff != LIMIT);

   always_comb begin
      push_item          = '0;
      push_item.digit    = c[3:0];
      push_item.negative = (c == CHAR_MINUS);
      push_item.scan_en  = scan_en;
      push_item.last     = req_bus.last_byte;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         push_item.cls = CLS_DIGIT;
      end else if (c == CHAR_POINT) begin
         push_item.cls = CLS_POINT;
      end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
         push_item.cls = CLS_SIGN;
      end else begin
         push_item.cls = CLS_OTHER;
      end
   end

   // Hold the count at the limit; restart on the final byte.
   always_comb begin
      count_in = count_ff;
      if (push) begin
         if (req_bus.last_byte) begin
            count_in = '0;
         end else if (scan_en) begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end
endmodule

@@ hw/rtl/alne_scan.sv @@
// Token scanner: walks the classified bytes and emits finished-token records.
module alne_scan (
   input  logic                   clock,
   input  logic                   reset,
   input  alne_pkg::scan_item_type item,
   input  logic                   item_valid,
   input  logic                   advance,
   output logic                   pop,
   output alne_pkg::finish_type   fin
);
   import alne_pkg::*;

   typedef enum logic [2:0] {
      SCAN_IDLE,
      SCAN_SIGN,
      SCAN_POINT,
      SCAN_INT,
      SCAN_FRAC
   } scan_state_type;

   scan_state_type state_ff, st_in;
   logic           neg_ff, neg_in;
   logic [31:0]    acc_ff, acc_in;
   logic [2:0]     fd_ff, fd_in;
   logic           rnd_ff, rnd_in;
   logic           ovf_ff, ovf_in;
   finish_type     fin_ff, fin_in;
   finish_type     rec;
   logic           fin_scan;
   logic           fin_last;
   logic           skip;
   logic [35:0]    acc_ten;

   assign pop = item_valid && advance;
   assign fin = fin_ff;

   always_comb begin
      st_in    = state_ff;
      neg_in   = neg_ff;
      acc_in   = acc_ff;
      fd_in    = fd_ff;
      rnd_in   = rnd_ff;
      ovf_in   = ovf_ff;
      fin_scan = 1'b0;
      fin_last = 1'b0;
      skip     = 1'b0;
      acc_ten  = '0;
      rec      = '0;

      if (item.scan_en) begin
         case (item.cls)
            CLS_DIGIT: begin
               if (state_ff == SCAN_IDLE) begin
                  neg_in = 1'b0;
                  acc_in = '0;
                  fd_in  = '0;
                  rnd_in = 1'b0;
                  ovf_in = 1'b0;
               end
               if (state_ff == SCAN_POINT || state_ff == SCAN_FRAC) begin
                  st_in = SCAN_FRAC;
               end else begin
                  st_in = SCAN_INT;
               end
               if (st_in == SCAN_FRAC) begin
                  if (fd_in == FRAC_KEEP) begin
                     rnd_in = (item.digit >= ROUND_DIGIT);
                     fd_in  = FRAC_KEEP + 3'd1;
                     skip   = 1'b1;
                  end else if (fd_in > FRAC_KEEP) begin
                     skip = 1'b1;
                  end else begin
                     fd_in = fd_in + 3'd1;
                  end
               end
               acc_ten = ({4'b0, acc_in} << 3) + ({4'b0, acc_in} << 1) + {32'b0, item.digit};
               if (!skip && !ovf_in) begin
                  if (acc_ten > {4'b0, MAG_CAP}) begin
                     ovf_in = 1'b1;
                  end else begin
                     acc_in = acc_ten[31:0];
                  end
               end
            end
            CLS_POINT: begin
               if (state_ff == SCAN_SIGN) begin
                  st_in = SCAN_POINT;
               end else if (state_ff == SCAN_INT) begin
                  st_in = SCAN_FRAC;
               end else begin
                  fin_scan = (state_ff == SCAN_FRAC);
                  neg_in   = 1'b0;
                  acc_in   = '0;
                  fd_in    = '0;
                  rnd_in   = 1'b0;
                  ovf_in   = 1'b0;
                  st_in    = SCAN_POINT;
               end
            end
            CLS_SIGN: begin
               fin_scan = (state_ff == SCAN_INT || state_ff == SCAN_FRAC);
               neg_in   = item.negative;
               acc_in   = '0;
               fd_in    = '0;
               rnd_in   = 1'b0;
               ovf_in   = 1'b0;
               st_in    = SCAN_SIGN;
            end
            default: begin
               fin_scan = (state_ff == SCAN_INT || state_ff == SCAN_FRAC);
               st_in    = SCAN_IDLE;
            end
         endcase
      end

      fin_last = item.last && (st_in == SCAN_INT || st_in == SCAN_FRAC);

      // A token ended by this byte comes from the held fields, one ended by
      // the final byte from the fields just updated.
      rec.fin_valid = fin_scan || fin_last;
      rec.emit      = item.last;
      if (fin_scan) begin
         rec.negative    = neg_ff;
         rec.round_up    = rnd_ff;
         rec.overflow    = ovf_ff;
         rec.frac_digits = fd_ff;
         rec.mag         = acc_ff;
      end else begin
         rec.negative    = neg_in;
         rec.round_up    = rnd_in;
         rec.overflow    = ovf_in;
         rec.frac_digits = fd_in;
         rec.mag         = acc_in;
      end

      if (item.last) begin
         st_in  = SCAN_IDLE;
         neg_in = 1'b0;
         acc_in = '0;
         fd_in  = '0;
         rnd_in = 1'b0;
         ovf_in = 1'b0;
      end

      fin_in = pop ? rec : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SCAN_IDLE;
         neg_ff   <= 1'b0;
         acc_ff   <= '0;
         fd_ff    <= '0;
         rnd_ff   <= 1'b0;
         ovf_ff   <= 1'b0;
         fin_ff   <= '0;
      end else begin
         if (pop) begin
            state_ff <= st_in;
            neg_ff   <= neg_in;
            acc_ff   <= acc_in;
            fd_ff    <= fd_in;
            rnd_ff   <= rnd_in;
            ovf_ff   <= ovf_in;
         end
         if (advance) begin
            fin_ff <= fin_in;
         end
      end
   end
endmodule

@@ hw/rtl/alne_fin.sv @@
// Value back end: scales, rounds and saturates tokens, keeps the latest, drives results.
module alne_fin (
   input  logic                 clock,
   input  logic                 reset,
   input  alne_pkg::finish_type fin,
   output logic                 advance,
   alne_rsp_if.source           rsp_bus
);
   import alne_pkg::*;

   logic              p_fin_ff;
   logic              p_emit_ff;
   logic              p_neg_ff;
   logic              p_rnd_ff;
   logic              p_ovf_ff;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [PROD_W-1:0] mag;
   logic              over;
   logic [31:0]       sat_value;
   logic [31:0]       latest_ff, latest_new;
   logic              found_ff, found_new;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_found_ff;
   logic [31:0]       rsp_value_ff;

   assign advance = !(p_emit_ff && rsp_valid_ff && !rsp_bus.ready);
   assign prod_in = {{SCALE_W{1'b0}}, fin.mag} * {32'b0, scale_factor(fin.frac_digits)};

   always_comb begin
      over = p_ovf_ff || (prod_ff > PROD_W'(MAG_CAP));
      mag  = prod_ff + PROD_W'(p_rnd_ff);
      if (p_neg_ff) begin
         if (over || mag > PROD_W'(MAG_CAP)) begin
            sat_value = MAG_CAP;
         end else begin
            sat_value = 32'd0 - mag[31:0];
         end
      end else begin
         if (over || mag > PROD_W'(MAG_CAP - 32'd1)) begin
            sat_value = MAG_CAP - 32'd1;
         end else begin
            sat_value = mag[31:0];
         end
      end
      latest_new   = p_fin_ff ? sat_value : latest_ff;
      found_new    = p_fin_ff || found_ff;
      rsp_valid_in = (rsp_valid_ff && !rsp_bus.ready) || (advance && p_emit_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_fin_ff     <= 1'b0;
         p_emit_ff    <= 1'b0;
         latest_ff    <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            p_fin_ff  <= fin.fin_valid;
            p_emit_ff <= fin.emit;
            if (p_emit_ff) begin
               latest_ff <= '0;
               found_ff  <= 1'b0;
            end else begin
               latest_ff <= latest_new;
               found_ff  <= found_new;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p_neg_ff <= fin.negative;
         p_rnd_ff <= fin.round_up;
         p_ovf_ff <= fin.overflow;
         prod_ff  <= prod_in;
         if (p_emit_ff) begin
            rsp_found_ff <= found_new;
            rsp_value_ff <= found_new ? latest_new : 32'd0;
         end
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.number_found = rsp_found_ff;
   assign rsp_bus.value        = $signed(rsp_value_ff);
endmodule

@@ hw/rtl/ascii_last_number_extractor.sv @@
// Top level of the extractor of the last decimal number in a text notification.
// Usage:
//   req_bus carries one text byte per item, with last_byte set on the final byte
//   of a notification. Only the first BUFFER_BYTES-1 bytes of a notification are
//   scanned; later bytes are taken and dropped until the final byte.
//   rsp_bus carries one item per notification: number_found and the last number
//   in units of 0.0001, rounded half away from zero, saturated to 32 bits signed.
// Throughput: one byte per cycle, sustained while the receiver takes results.
// Result path: after the final byte is taken it passes the queue entry, the
//   finished-token register and the product register before rsp_bus.valid
//   rises from the result register.
// Reset (synchronous, active high): queue, scanner and stored value clear; no
//   result is pending afterwards.
// Receiver stall: the result is held in its register; the value stages freeze
//   only when a second result is waiting behind it, then the four-entry queue
//   fills and req_bus.ready drops.
module ascii_last_number_extractor #(
   parameter int BUFFER_BYTES = alne_pkg::BUFFER_BYTES_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   alne_req_if.sink   req_bus,
   alne_rsp_if.source rsp_bus
);
   import alne_pkg::*;

   scan_item_type push_item;
   scan_item_type head_item;
   finish_type    fin;
   logic          push;
   logic          pop;
   logic          queue_full;
   logic          queue_not_empty;
   logic          advance;

   // Front: take and classify bytes
   alne_front #(
      .BUFFER_BYTES(BUFFER_BYTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .queue_full(queue_full),
      .push      (push),
      .push_item (push_item)
   );

   // Queue: decouple intake from the scanner so each side stalls on its own
   alne_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_item(push_item),
      .pop      (pop),
      .head_item(head_item),
      .not_empty(queue_not_empty),
      .full     (queue_full)
   );

   // Back: token state machine
   alne_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .item      (head_item),
      .item_valid(queue_not_empty),
      .advance   (advance),
      .pop       (pop),
      .fin       (fin)
   );

   // Back: scale, round, saturate and deliver
   alne_fin u_fin (
      .clock  (clock),
      .reset  (reset),
      .fin    (fin),
      .advance(advance),
      .rsp_bus(rsp_bus)
   );
endmodule

@@ hw/rtl/alne_checker.sv @@
// Port-level checks of the extractor and their binding to the top level.
`include "ascii_last_number_extractor_macros.svh"

module alne_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_last,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_found,
   input logic [31:0] rsp_value
);
   logic [3:0] pending_ff, pending_in;

   // Final bytes taken but not yet answered.
   assign pending_in = pending_ff + 4'(req_valid && req_ready && req_last)
                     - 4'(rsp_valid && rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `ALNE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_value) && $stable(rsp_found), "result changed while stalled")
   `ALNE_ASSERT_NOW(a_none_is_zero, rsp_valid && !rsp_found, rsp_value == 32'd0, "value not zero without a number")
   `ALNE_ASSERT_NOW(a_rsp_has_cause, rsp_valid, pending_ff != 4'd0, "result without a final byte")
   `ALNE_ASSERT_NOW(a_reset_clears, $past(reset), !rsp_valid, "result pending right after reset")
endmodule

bind ascii_last_number_extractor alne_checker u_alne_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_bus.valid),
   .req_ready(req_bus.ready),
   .req_last (req_bus.last_byte),
   .rsp_valid(rsp_bus.valid),
   .rsp_ready(rsp_bus.ready),
   .rsp_found(rsp_bus.number_found),
   .rsp_value(rsp_bus.value)
);

@@ test/tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the last-number extractor: text bytes in, parsed number out.
module tb;
   import alne_pkg::*;

   localparam int SCAN_LIMIT    = BUFFER_BYTES_DEFAULT - 1;
   localparam int RANDOM_BYTES  = 900;
   localparam int STEADY_BYTES  = 200;
   localparam int HOLD_CYCLES   = 400;
   localparam int DRAIN_CYCLES  = 12;
   localparam int CYCLE_LIMIT   = 100000;
   localparam logic [63:0] MAG_LIMIT = 64'(MAG_CAP);

   typedef enum logic [2:0] {
      SCAN_IDLE,
      SCAN_SIGN,
      SCAN_POINT,
      SCAN_INT,
      SCAN_FRAC
   } scan_phase_type;

   typedef struct {
      logic               found;
      logic signed [31:0] value;
   } number_result_type;

   typedef logic [7:0] text_q_type[$];

   logic clock;
   logic reset;

   alne_req_if req_bus ();
   alne_rsp_if rsp_bus ();

   ascii_last_number_extractor dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Scanner state mirrored from the block's behaviour.
   int unsigned    seen_bytes;
   scan_phase_type phase;
   logic           tok_negative;
   logic [31:0]    tok_digits;
   int             tok_frac;
   logic           tok_round;
   logic           tok_overflow;
   logic [31:0]    last_number;
   logic           any_number;

   // Numbers still owed by the block, oldest first.
   number_result_type pending_numbers[$];
   number_result_type want;

   int  failures;
   int  cycle_count;
   int  random_bytes;
   int  hold_cycles;
   bit  sender_gaps;
   bit  receiver_stalls;

   // Clock: 2 ns period.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog: end the run if the block stops making progress.
   initial begin
      for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
         @(posedge clock);
      $display("simulation failed");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Number predictor
   // ---------------------------------------------------------------------

   function automatic void open_token(input logic negative, input scan_phase_type start);
      tok_negative = negative;
      tok_digits   = '0;
      tok_frac     = 0;
      tok_round    = 1'b0;
      tok_overflow = 1'b0;
      phase        = start;
   endfunction

   // Fold the token in progress into the latest number, if it holds a digit.
   function automatic void close_token();
      logic [63:0] mag;
      int          k;
      if (phase == SCAN_INT || phase == SCAN_FRAC) begin
         mag = 64'(tok_digits);
         // scale up to four fraction digits; flag anything beyond the cap
         for (k = tok_frac; k < FRAC_KEEP; k++) begin
            mag = mag * 10;
            if (mag > MAG_LIMIT) tok_overflow = 1'b1;
         end
         if (tok_round) mag = mag + 1;
         if (tok_negative) begin
            if (tok_overflow || mag > MAG_LIMIT) mag = MAG_LIMIT;
            last_number = -mag[31:0];
         end else begin
            if (tok_overflow || mag > MAG_LIMIT - 1) mag = MAG_LIMIT - 1;
            last_number = mag[31:0];
         end
         any_number = 1'b1;
      end
      phase = SCAN_IDLE;
   endfunction

   function automatic void clear_scan();
      seen_bytes  = 0;
      last_number = '0;
      any_number  = 1'b0;
      open_token(1'b0, SCAN_IDLE);
   endfunction

   // Advance the mirrored scanner by one accepted item; queue a number on the last byte.
   function automatic void predict_byte(input logic [7:0] c, input logic last);
      logic [63:0] grown;
      if (seen_bytes < SCAN_LIMIT) begin
         if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            if (phase == SCAN_IDLE) open_token(1'b0, SCAN_INT);
            else if (phase == SCAN_SIGN) phase = SCAN_INT;
            else if (phase == SCAN_POINT) phase = SCAN_FRAC;
            if (phase == SCAN_FRAC && tok_frac >= FRAC_KEEP) begin
               // fifth fraction digit only decides rounding; later ones drop
               if (tok_frac == FRAC_KEEP) begin
                  tok_round = ((c - CHAR_ZERO) >= ROUND_DIGIT);
                  tok_frac++;
               end
            end else begin
               if (phase == SCAN_FRAC) tok_frac++;
               if (!tok_overflow) begin
                  grown = 64'(tok_digits) * 10 + 64'(c - CHAR_ZERO);
                  if (grown > MAG_LIMIT) tok_overflow = 1'b1;
                  else tok_digits = grown[31:0];
               end
            end
         end else if (c == CHAR_POINT) begin
            if (phase == SCAN_SIGN) phase = SCAN_POINT;
            else if (phase == SCAN_INT) phase = SCAN_FRAC;
            else begin
               // second point or bare point: restart here
               close_token();
               open_token(1'b0, SCAN_POINT);
            end
         end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
            close_token();
            open_token(c == CHAR_MINUS, SCAN_SIGN);
         end else begin
            close_token();
         end
         seen_bytes++;
      end
      if (last) begin
         close_token();
         pending_numbers.push_back('{any_number, any_number ? $signed(last_number) : 32'sd0});
         clear_scan();
      end
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   function automatic text_q_type text_of(input string s);
      text_q_type q;
      for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
      return q;
   endfunction

   // Build one notification: mostly runs of tokens, some raw noise, some boundary numbers.
   function automatic text_q_type random_message();
      text_q_type msg;
      string      seps;
      int         shape;
      int         target;
      int         ndigits;
      seps  = " ,;:=V%\n";
      shape = $urandom_range(0, 99);
      if (shape < 10) begin
         // raw noise of any byte value
         repeat ($urandom_range(1, 16)) msg.push_back(8'($urandom_range(0, 255)));
      end else if (shape < 16) begin
         case ($urandom_range(0, 8))
            0: msg = text_of("214748.3647");
            1: msg = text_of("214748.3648");
            2: msg = text_of("-214748.3648");
            3: msg = text_of("-214748.3649");
            4: msg = text_of("214748.36475");
            5: msg = text_of("-214748.36485");
            6: msg = text_of("2147483648");
            7: msg = text_of("0.00005");
            default: msg = text_of("-0.00004");
         endcase
      end else begin
         // a few notifications run past the scan limit
         target = (shape < 22) ? $urandom_range(60, 80) : $urandom_range(1, 24);
         while (msg.size() < target) begin
            case ($urandom_range(0, 9))
               0:       msg.push_back(CHAR_PLUS);
               1, 2:    msg.push_back(CHAR_MINUS);
               default: ;
            endcase
            ndigits = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 14)
                                                   : $urandom_range(0, 4);
            repeat (ndigits) msg.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
            if ($urandom_range(0, 1) == 1) begin
               msg.push_back(CHAR_POINT);
               repeat ($urandom_range(0, 7))
                  msg.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
            end
            case ($urandom_range(0, 7))
               0:       ;  // let tokens run together
               1:       msg.push_back(8'($urandom_range(0, 255)));
               default: msg.push_back(seps[$urandom_range(0, seps.len() - 1)]);
            endcase
         end
      end
      return msg;
   endfunction

   // Offer one item from a falling edge; return at the falling edge after acceptance.
   task automatic send_byte(input logic [7:0] c, input logic last);
      while (sender_gaps && $urandom_range(0, 99) < 30) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= c;
      req_bus.last_byte <= last;
      do @(posedge clock); while (!req_bus.ready);
      predict_byte(c, last);
      @(negedge clock);
   endtask

   task automatic send_text(input text_q_type msg);
      foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Cover byte extremes, bare-point and trailing-point tokens, sign restart,
   // rounding carry, second point, a prefix that never completes and saturation.
   task automatic test_directed_cases();
      text_q_type msg;
      msg = text_of("-.5");
      msg.push_front(8'hFF);
      msg.push_back(8'h00);
      send_text(msg);
      send_text(text_of("5."));
      send_text(text_of("+-3.99995"));
      send_text(text_of("1.2.3"));
      send_text(text_of("+."));
      send_text(text_of("-214749"));
      send_text(text_of("214749,"));
   endtask

   // Tokens cut short by the scan limit, and a digit run that overflows up to it.
   task automatic test_scan_limit();
      text_q_type msg;
      repeat (SCAN_LIMIT - 5) msg.push_back(8'h20);
      msg = {msg, text_of("-1234567 89")};
      send_text(msg);
      msg = text_of("1.5 ");
      repeat (70) msg.push_back(CHAR_NINE);
      send_text(msg);
   endtask

   // Hold the result side off while short notifications keep coming, so the
   // queue fills and the byte channel stalls.
   task automatic test_receiver_hold();
      sender_gaps = 1'b0;
      hold_cycles = HOLD_CYCLES;
      repeat (24) send_text(text_of("7"));
      sender_gaps = 1'b1;
   endtask

   // Back-to-back items with the result side always ready.
   task automatic test_steady_stream();
      text_q_type msg;
      sender_gaps     = 1'b0;
      receiver_stalls = 1'b0;
      while (random_bytes < STEADY_BYTES) begin
         msg = random_message();
         random_bytes += msg.size();
         send_text(msg);
      end
      sender_gaps     = 1'b1;
      receiver_stalls = 1'b1;
   endtask

   task automatic test_random_messages();
      text_q_type msg;
      while (random_bytes < RANDOM_BYTES) begin
         msg = random_message();
         random_bytes += msg.size();
         send_text(msg);
      end
   endtask

   // ---------------------------------------------------------------------
   // Result side
   // ---------------------------------------------------------------------

   // Drive ready at falling edges: a long hold when asked, else random stalls when enabled.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_cycles--;
         end else begin
            rsp_bus.ready <= !receiver_stalls || $urandom_range(0, 99) >= 30;
         end
      end
   end

   // Compare each accepted result with the oldest number owed.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_numbers.size() == 0) begin
            $error("unexpected result: number_found %0d value %0d",
                   rsp_bus.number_found, rsp_bus.value);
            failures++;
         end else begin
            want = pending_numbers.pop_front();
            if (rsp_bus.number_found !== want.found) begin
               $error("number_found: expected %0d, got %0d", want.found, rsp_bus.number_found);
               failures++;
            end
            if (rsp_bus.value !== want.value) begin
               $error("value: expected %0d, got %0d", want.value, rsp_bus.value);
               failures++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------

   initial begin
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.data_byte = '0;
      req_bus.last_byte = 1'b0;
      failures          = 0;
      random_bytes      = 0;
      hold_cycles       = 0;
      sender_gaps       = 1'b1;
      receiver_stalls   = 1'b1;
      clear_scan();

      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_cases();
      test_scan_limit();
      test_receiver_hold();
      test_steady_stream();
      test_random_messages();
      req_bus.valid <= 1'b0;

      // Drain: wait for every owed number, then allow for stray results.
      while (pending_numbers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (failures == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/alne_pkg.sv
hw/rtl/alne_req_if.sv
hw/rtl/alne_rsp_if.sv
hw/rtl/alne_fifo.sv
hw/rtl/alne_front.sv
hw/rtl/alne_scan.sv
hw/rtl/alne_fin.sv
hw/rtl/ascii_last_number_extractor.sv
hw/rtl/alne_checker.sv
test/tb.sv
